// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset
`define RMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Check an implication in the following cycle
`define RMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// Shared types and constants for the matrix to quaternion pipeline
`default_nettype none
package rmq_pkg;
    localparam int FRAC_BITS_DEF = 14;
    localparam int D_W = 17;   // off-diagonal sum or difference
    localparam int Q_W = 16;   // result component
    localparam int QB  = 17;   // quotient bits resolved by the divider

    typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} br_t;

    typedef struct packed {
        br_t                   br;
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] d1;
        logic signed [D_W-1:0] d2;
    } side_t;

    typedef struct packed {
        br_t                   br;
        logic signed [Q_W-1:0] own;
    } tag_t;
endpackage
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Top level: rotation matrix to unit quaternion pipeline
// Converts one 3x3 rotation matrix per cycle into its quaternion (w, x, y, z),
// all in signed fixed point with FRAC_BITS fraction bits, picking the branch by
// positive trace or largest diagonal entry. The stages are one input stage,
// one stage per root bit in the square root (SQ_W, half the radicand width),
// one setup stage and 17 quotient-bit stages in the dividers, and the output
// register. Throughput is one item per cycle while the output is not stalled;
// each stage holds its beat under back-pressure and empty stages keep filling,
// so stalls lose nothing. Non-rotation inputs clamp t to one step and all
// components saturate to 16 bits.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [15:0]    s_r00,
    input  wire logic signed [15:0]    s_r01,
    input  wire logic signed [15:0]    s_r02,
    input  wire logic signed [15:0]    s_r10,
    input  wire logic signed [15:0]    s_r11,
    input  wire logic signed [15:0]    s_r12,
    input  wire logic signed [15:0]    s_r20,
    input  wire logic signed [15:0]    s_r21,
    input  wire logic signed [15:0]    s_r22,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [Q_W-1:0]      m_quat_w,
    output logic signed [Q_W-1:0]      m_quat_x,
    output logic signed [Q_W-1:0]      m_quat_y,
    output logic signed [Q_W-1:0]      m_quat_z
);
    localparam int  T_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int  V_W  = T_W + FRAC_BITS;
    localparam int  RW   = V_W + (V_W % 2);
    localparam int  SQ_W = RW / 2;
    localparam int  DS0  = SQ_W + 1;          // divider setup stage
    localparam int  NST  = SQ_W + QB + 3;     // all stages incl. output
    localparam longint ONE = 64'sd1 << FRAC_BITS;

    // Stage valid bits and load enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        if (k == NST - 1) begin : g_last
            assign en[k] = !vld_reg[k] || m_ready;
        end else begin : g_mid
            assign en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];

    // Pick the branch, form t and the off-diagonal terms
    logic signed [17:0]  tr;
    logic signed [T_W:0] t_raw;
    logic [T_W-1:0]      t_cl;
    logic [RW-1:0]       rad_c;
    side_t               side_c;

    assign tr = 18'(s_r00) + 18'(s_r11) + 18'(s_r22);

    always_comb begin
        side_c = '0;
        if (tr > 18'sd0) begin
            side_c.br = BR_W;
            t_raw     = (T_W+1)'(ONE) + (T_W+1)'(tr);
            side_c.d0 = D_W'(s_r21) - D_W'(s_r12);
            side_c.d1 = D_W'(s_r02) - D_W'(s_r20);
            side_c.d2 = D_W'(s_r10) - D_W'(s_r01);
        end else if (s_r00 > s_r11 && s_r00 > s_r22) begin
            side_c.br = BR_X;
            t_raw     = (T_W+1)'(ONE) + (T_W+1)'(s_r00) - (T_W+1)'(s_r11)
                      - (T_W+1)'(s_r22);
            side_c.d0 = D_W'(s_r21) - D_W'(s_r12);
            side_c.d1 = D_W'(s_r10) + D_W'(s_r01);
            side_c.d2 = D_W'(s_r20) + D_W'(s_r02);
        end else if (s_r11 > s_r22) begin
            side_c.br = BR_Y;
            t_raw     = (T_W+1)'(ONE) + (T_W+1)'(s_r11) - (T_W+1)'(s_r00)
                      - (T_W+1)'(s_r22);
            side_c.d0 = D_W'(s_r02) - D_W'(s_r20);
            side_c.d1 = D_W'(s_r10) + D_W'(s_r01);
            side_c.d2 = D_W'(s_r21) + D_W'(s_r12);
        end else begin
            side_c.br = BR_Z;
            t_raw     = (T_W+1)'(ONE) + (T_W+1)'(s_r22) - (T_W+1)'(s_r00)
                      - (T_W+1)'(s_r11);
            side_c.d0 = D_W'(s_r10) - D_W'(s_r01);
            side_c.d1 = D_W'(s_r02) + D_W'(s_r20);
            side_c.d2 = D_W'(s_r12) + D_W'(s_r21);
        end
    end

    // Clamp non-positive t to one step, scale for the root
    assign t_cl  = (t_raw < (T_W+1)'(1)) ? T_W'(1) : t_raw[T_W-1:0];
    assign rad_c = RW'(t_cl) << FRAC_BITS;

    logic [RW-1:0] rad_reg;
    side_t         side_reg [SQ_W+1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rad_reg     <= rad_c;
            side_reg[0] <= side_c;
        end
    end

    // Carry the branch and terms alongside the root stages
    for (genvar k = 1; k <= SQ_W; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic [SQ_W-1:0] root;

    rmq_sqrt #(.RW(RW)) u_sqrt (
        .aclk     (aclk),
        .en       (en[SQ_W:1]),
        .rad_in   (rad_reg),
        .root_out (root)
    );

    // Own component is the root halved with rounding
    logic [SQ_W:0]  own_full;
    tag_t           tag_c;
    tag_t           tag_reg [QB+1];

    assign own_full  = ({1'b0, root} + (SQ_W+1)'(1)) >> 1;
    assign tag_c.br  = side_reg[SQ_W].br;
    assign tag_c.own = (own_full > (SQ_W+1)'(32767)) ? 16'sh7fff : Q_W'(own_full);

    for (genvar k = 0; k <= QB; k++) begin : g_tag
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en[DS0]) begin
                    tag_reg[0] <= tag_c;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (en[DS0+k]) begin
                    tag_reg[k] <= tag_reg[k-1];
                end
            end
        end
    end

    logic signed [Q_W-1:0] q0;
    logic signed [Q_W-1:0] q1;
    logic signed [Q_W-1:0] q2;

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SQ_W(SQ_W)) u_div0 (
        .aclk (aclk), .en (en[DS0+QB:DS0]),
        .d_in (side_reg[SQ_W].d0), .root_in (root), .q_out (q0)
    );
    rmq_div #(.FRAC_BITS(FRAC_BITS), .SQ_W(SQ_W)) u_div1 (
        .aclk (aclk), .en (en[DS0+QB:DS0]),
        .d_in (side_reg[SQ_W].d1), .root_in (root), .q_out (q1)
    );
    rmq_div #(.FRAC_BITS(FRAC_BITS), .SQ_W(SQ_W)) u_div2 (
        .aclk (aclk), .en (en[DS0+QB:DS0]),
        .d_in (side_reg[SQ_W].d2), .root_in (root), .q_out (q2)
    );

    // Place own component and quotients by branch
    logic signed [Q_W-1:0] w_next, x_next, y_next, z_next;
    logic signed [Q_W-1:0] w_reg, x_reg, y_reg, z_reg;
    tag_t                  tag_fin;

    assign tag_fin = tag_reg[QB];

    always_comb begin
        case (tag_fin.br)
            BR_W: begin
                w_next = tag_fin.own; x_next = q0; y_next = q1; z_next = q2;
            end
            BR_X: begin
                w_next = q0; x_next = tag_fin.own; y_next = q1; z_next = q2;
            end
            BR_Y: begin
                w_next = q0; x_next = q1; y_next = tag_fin.own; z_next = q2;
            end
            default: begin
                w_next = q0; x_next = q1; y_next = q2; z_next = tag_fin.own;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            w_reg <= w_next;
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign m_quat_w = w_reg;
    assign m_quat_x = x_reg;
    assign m_quat_y = y_reg;
    assign m_quat_z = z_reg;

    // Checks
    `RMQ_ASSERT_NXT(a_in_lands, aclk, aresetn, s_valid && s_ready, vld_reg[0],
        "accepted beat did not land in the input stage")
    `RMQ_ASSERT_IMP(a_ready_full, aclk, aresetn, !s_ready, vld_reg[0] && vld_reg[NST-1],
        "input stalled while the pipeline has room")
    `RMQ_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_quat_w) && $stable(m_quat_x) && $stable(m_quat_y)
        && $stable(m_quat_z), "result beat changed while stalled")
    `RMQ_ASSERT_IMP(a_tag_own, aclk, aresetn, vld_reg[NST-2], !tag_fin.own[Q_W-1],
        "own component went negative")
endmodule
`default_nettype wire

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage
`default_nettype none
module rmq_sqrt import rmq_pkg::*; #(
    parameter int RW = 34
) (
    input  wire logic              aclk,
    input  wire logic [RW/2-1:0]   en,
    input  wire logic [RW-1:0]     rad_in,
    output logic      [RW/2-1:0]   root_out
);
    localparam int SQ_W = RW / 2;

    logic [RW-1:0]   rem_reg  [SQ_W-1];
    logic [SQ_W-1:0] root_reg [SQ_W];

    for (genvar i = 0; i < SQ_W; i++) begin : g_st
        localparam int B = SQ_W - 1 - i;
        logic [RW:0]     rem_in;
        logic [RW:0]     test;
        logic [SQ_W-1:0] root_in;
        logic            ge;

        if (i == 0) begin : g_first
            assign rem_in  = {1'b0, rad_in};
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = {1'b0, rem_reg[i-1]};
            assign root_in = root_reg[i-1];
        end

        // Trial subtract of (2*root + 2^B) * 2^B
        assign test = ({{(RW+1-SQ_W){1'b0}}, root_in} << (B + 1))
                    + ((RW+1)'(1) << (2 * B));
        assign ge   = rem_in >= test;

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                root_reg[i] <= ge ? (root_in | (SQ_W'(1) << B)) : root_in;
            end
        end

        if (i < SQ_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en[i]) begin
                    rem_reg[i] <= ge ? RW'(rem_in - test) : RW'(rem_in);
                end
            end
        end
    end

    assign root_out = root_reg[SQ_W-1];
endmodule
`default_nettype wire

// ===== rtl/rmq_div.sv =====
// Pipelined rounded divide of one off-diagonal term by twice the root
`default_nettype none
module rmq_div import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SQ_W      = 17
) (
    input  wire logic                  aclk,
    input  wire logic [QB:0]           en,
    input  wire logic signed [D_W-1:0] d_in,
    input  wire logic [SQ_W-1:0]       root_in,
    output logic signed [Q_W-1:0]      q_out
);
    localparam int NW0 = (D_W + FRAC_BITS > SQ_W) ? D_W + FRAC_BITS : SQ_W;
    localparam int NW  = NW0 + 1;
    localparam int CW  = (NW > SQ_W + 1 + QB) ? NW : SQ_W + 1 + QB;

    logic [CW-1:0]   num_reg [QB];
    logic [SQ_W:0]   den_reg [QB];
    logic            neg_reg [QB+1];
    logic            ovf_reg [QB+1];
    logic [QB-1:0]   q_reg   [QB];

    logic [D_W-1:0]  mag;
    logic [CW-1:0]   num_c;
    logic [SQ_W:0]   den_c;

    // Form |d| * 2^F + root over 2 * root
    assign mag   = d_in[D_W-1] ? D_W'(-d_in) : D_W'(d_in);
    assign num_c = (CW'(mag) << FRAC_BITS) + CW'(root_in);
    assign den_c = {root_in, 1'b0};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            num_reg[0] <= num_c;
            den_reg[0] <= den_c;
            neg_reg[0] <= d_in[D_W-1];
            ovf_reg[0] <= num_c >= (CW'(den_c) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_st
        localparam int B = QB - j;
        logic [CW-1:0] sub;
        logic [QB-1:0] q_in;
        logic          ge;

        if (j == 1) begin : g_first
            assign q_in = '0;
        end else begin : g_rest
            assign q_in = q_reg[j-2];
        end

        assign sub = CW'(den_reg[j-1]) << B;
        assign ge  = num_reg[j-1] >= sub;

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                q_reg[j-1] <= ge ? (q_in | (QB'(1) << B)) : q_in;
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end

        if (j < QB) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en[j]) begin
                    num_reg[j] <= ge ? (num_reg[j-1] - sub) : num_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    // Saturate and apply sign
    logic          big;
    logic [QB-1:0] q_fin;
    assign q_fin = q_reg[QB-1];
    assign big   = ovf_reg[QB] | q_fin[QB-1] | q_fin[Q_W-1];

    always_comb begin
        if (neg_reg[QB]) begin
            q_out = big ? {1'b1, {(Q_W-1){1'b0}}} : Q_W'(-q_fin[Q_W-1:0]);
        end else begin
            q_out = big ? {1'b0, {(Q_W-1){1'b1}}} : q_fin[Q_W-1:0];
        end
    end
endmodule
`default_nettype wire
